// File: hdl/cpid_pkg.sv
// ----------------------------------------------------------------------------
// cpid_pkg
// Types, constants and helper functions shared by the column-post decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cpid_pkg;

	localparam int DIM_W     = 10;
	localparam int ROW_W     = 8;
	localparam int INDEX_W   = 8;
	localparam int COLOR_W   = 32;
	localparam int ADDR_W    = 18;
	localparam int PAL_DEPTH = 256;

	localparam logic [DIM_W-1:0] MAX_DIM       = DIM_W'(512);
	localparam logic [DIM_W-1:0] COUNTER_MAX   = {DIM_W{1'b1}};
	localparam logic [DIM_W-1:0] RESET_WIDTH   = DIM_W'(64);
	localparam logic [DIM_W-1:0] RESET_HEIGHT  = DIM_W'(64);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_PALETTE    = 2'd0,
		ACT_POST_START = 2'd1,
		ACT_POST_PIXEL = 2'd2,
		ACT_COLUMN_END = 2'd3
	} action_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_index_t;

	// One queued job for the back end: a palette write or a pixel lookup.
	typedef struct packed {
		logic               is_pixel;
		logic [INDEX_W-1:0] index;
		logic [COLOR_W-1:0] color;
		logic [ADDR_W-1:0]  address;
		logic               oor;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	function automatic logic [DIM_W-1:0] sat_inc(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = (v == COUNTER_MAX) ? v : v + DIM_W'(1);
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = (v > MAX_DIM) ? MAX_DIM : v;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/cpid_in_if.sv
// ----------------------------------------------------------------------------
// cpid_in_if
// Input stream channel: one picture-stream item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpid_in_if;
	import cpid_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [ROW_W-1:0]   post_top;
	logic [INDEX_W-1:0] palette_index;
	logic [COLOR_W-1:0] color_word;
	logic               end_of_image;

	modport source (
		output valid, action, post_top, palette_index, color_word, end_of_image,
		input  ready
	);

	modport sink (
		input  valid, action, post_top, palette_index, color_word, end_of_image,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/cpid_out_if.sv
// ----------------------------------------------------------------------------
// cpid_out_if
// Result channel: one frame-buffer write per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpid_out_if;
	import cpid_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               out_of_range;

	modport source (
		output valid, pixel_address, pixel_color, out_of_range,
		input  ready
	);

	modport sink (
		input  valid, pixel_address, pixel_color, out_of_range,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/cpid_cfg_if.sv
// ----------------------------------------------------------------------------
// cpid_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpid_cfg_if;
	import cpid_pkg::*;

	logic             valid;
	logic             ready;
	logic [0:0]       index;
	logic [DIM_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/cpid_front.sv
// ----------------------------------------------------------------------------
// cpid_front
// Accepts stream items, keeps the row and column counters and the picture
// size, computes the frame-buffer address and queues palette and pixel jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module cpid_front (
	input  logic                  clk,
	input  logic                  arst_n,
	cpid_in_if.sink               stream,
	cpid_cfg_if.sink              cfg,
	input  cpid_pkg::fifo_status_t status,
	output logic                  push,
	output cpid_pkg::entry_t      entry
);
	import cpid_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   col_q;
	logic [DIM_W-1:0]   row_q;
	logic               accept;
	action_t            action;
	logic [DIM_W-1:0]   w_c;
	logic [DIM_W-1:0]   h_c;
	logic               oor;
	logic [2*DIM_W-1:0] prod;
	logic [2*DIM_W-1:0] sum;

	assign stream.ready = !status.full;
	assign cfg.ready    = 1'b1;
	assign accept       = stream.valid && stream.ready;
	assign action       = action_t'(stream.action);

	assign w_c  = clamp_dim(width_q);
	assign h_c  = clamp_dim(height_q);
	assign oor  = (row_q >= h_c) || (col_q >= w_c);
	assign prod = row_q * w_c;
	assign sum  = prod + {{DIM_W{1'b0}}, col_q};

	always_comb begin
		entry.is_pixel = (action == ACT_POST_PIXEL);
		entry.index    = stream.palette_index;
		entry.color    = stream.color_word;
		entry.oor      = oor;
		entry.address  = oor ? '0 : sum[ADDR_W-1:0];
	end

	// Post starts and column ends only move the counters; nothing is queued.
	assign push = accept && ((action == ACT_PALETTE) || (action == ACT_POST_PIXEL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.index))
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			unique case (action)
				ACT_PALETTE:    ;
				ACT_POST_START: row_q <= {{(DIM_W-ROW_W){1'b0}}, stream.post_top};
				ACT_POST_PIXEL: row_q <= sat_inc(row_q);
				ACT_COLUMN_END: col_q <= sat_inc(col_q);
			endcase
			if (stream.end_of_image) begin
				col_q <= '0;
			end
		end
	end
endmodule

`default_nettype wire

// File: hdl/cpid_fifo.sv
// ----------------------------------------------------------------------------
// cpid_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cpid_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cpid_pkg::entry_t       wr_entry,
	input  logic                   pop,
	output cpid_pkg::entry_t       rd_entry,
	output cpid_pkg::fifo_status_t status
);
	import cpid_pkg::*;

	entry_t           slots_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_entry     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule

`default_nettype wire

// File: hdl/cpid_back.sv
// ----------------------------------------------------------------------------
// cpid_back
// Carries out queued jobs: writes the palette memory, or reads it for a pixel
// and presents the frame-buffer write on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cpid_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cpid_pkg::entry_t       job,
	input  cpid_pkg::fifo_status_t status,
	output logic                   pop,
	cpid_out_if.source             result
);
	import cpid_pkg::*;

	logic [COLOR_W-1:0] palette_q [PAL_DEPTH];
	logic [COLOR_W-1:0] color_q;
	logic [ADDR_W-1:0]  address_q;
	logic               oor_q;
	logic               valid_q;
	logic               slot_free;
	logic               do_read;
	logic               do_write;

	// A palette write never needs the output slot, so it drains even while
	// a result is stalled.
	assign slot_free = !valid_q || result.ready;
	assign pop       = !status.empty && (!job.is_pixel || slot_free);
	assign do_read   = pop && job.is_pixel;
	assign do_write  = pop && !job.is_pixel;

	always_ff @(posedge clk) begin
		if (do_write) begin
			palette_q[job.index] <= job.color;
		end
		if (do_read) begin
			color_q <= palette_q[job.index];
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			address_q <= job.address;
			oor_q     <= job.oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= do_read;
		end
	end

	assign result.valid         = valid_q;
	assign result.pixel_address = address_q;
	assign result.pixel_color   = color_q;
	assign result.out_of_range  = oor_q;
endmodule

`default_nettype wire

// File: hdl/column_post_image_decoder.sv
// A pixel item accepted from the stream is written into the queue, then popped by the
// back end, which reads the palette into the registers that drive the result channel.
// Throughput: one item per cycle; the input stalls only while the four-entry
// queue is full, which a stalled result causes.
// Reset: asynchronous, active low; clears the counters, the queue and the
// output valid, and sets the picture size to 64 by 64. The palette is not reset.
// ----------------------------------------------------------------------------
// column_post_image_decoder
// Turns a column-post picture stream into frame-buffer writes.
// ----------------------------------------------------------------------------
`default_nettype none

module column_post_image_decoder (
	input  logic       clk,
	input  logic       arst_n,
	cpid_in_if.sink    stream,
	cpid_cfg_if.sink   cfg,
	cpid_out_if.source result
);
	import cpid_pkg::*;

	logic         push;
	logic         pop;
	entry_t       wr_entry;
	entry_t       rd_entry;
	fifo_status_t status;

	cpid_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.cfg    (cfg),
		.status (status),
		.push   (push),
		.entry  (wr_entry)
	);

	cpid_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (status)
	);

	cpid_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (rd_entry),
		.status (status),
		.pop    (pop),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_oor_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.out_of_range |-> result.pixel_address == '0)
		else $error("out-of-range write with nonzero address");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("job queued while the queue is full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("job taken from an empty queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.pixel_color))
		else $error("stalled result changed");
`endif
endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the column-post decoder against a cycle-free predictor of its
// palette, row and column state. A short table of directed items runs
// first, then the row counter is driven into saturation, then several
// phases of random column-post streams under different picture sizes.
// Both the stream sender and the result receiver idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import cpid_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 100;
	localparam int NUM_PHASES     = 8;

	typedef struct packed {
		action_t            act;
		logic [ROW_W-1:0]   top;
		logic [INDEX_W-1:0] idx;
		logic [COLOR_W-1:0] color;
		logic               eoi;
	} stream_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               oor;
	} fb_write_t;

	typedef struct {
		stream_item_t item;
		bit           typed;
		fb_write_t    want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cpid_in_if  stream_if ();
	cpid_cfg_if cfg_if ();
	cpid_out_if result_if ();

	column_post_image_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.cfg    (cfg_if),
		.result (result_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state.
	logic [COLOR_W-1:0] pal_color [PAL_DEPTH];
	bit                 pal_written [PAL_DEPTH];
	logic [DIM_W-1:0]   cur_col;
	logic [DIM_W-1:0]   cur_row;
	logic [DIM_W-1:0]   cfg_width;
	logic [DIM_W-1:0]   cfg_height;

	fb_write_t pending_writes [$];
	dir_row_t  dir_rows [$];

	int  err_count   = 0;
	int  items_sent  = 0;
	int  rx_hold_len = 0;
	bit  tx_burst    = 1'b0;
	bit  rx_fast     = 1'b0;
	bit  rx_started  = 1'b0;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_W'(512)) ? DIM_W'(512) : v;
	endfunction

	// Advances the predicted state by one item; returns 1 when it yields a write.
	function automatic bit decode_item(input stream_item_t it, output fb_write_t wr);
		logic [DIM_W-1:0] w_eff;
		logic [DIM_W-1:0] h_eff;
		logic [19:0]      lin;
		bit               has;
		w_eff = eff_dim(cfg_width);
		h_eff = eff_dim(cfg_height);
		has = 1'b0;
		wr = '0;
		case (it.act)
			ACT_PALETTE: begin
				pal_color[it.idx] = it.color;
				pal_written[it.idx] = 1'b1;
			end
			ACT_POST_START: begin
				cur_row = DIM_W'(it.top);
			end
			ACT_POST_PIXEL: begin
				wr.oor = (cur_row >= h_eff) || (cur_col >= w_eff);
				lin = 20'(cur_row) * 20'(w_eff) + 20'(cur_col);
				wr.addr = wr.oor ? '0 : lin[ADDR_W-1:0];
				wr.color = pal_color[it.idx];
				has = 1'b1;
				if (cur_row != {DIM_W{1'b1}})
					cur_row = cur_row + DIM_W'(1);
			end
			default: begin
				if (cur_col != {DIM_W{1'b1}})
					cur_col = cur_col + DIM_W'(1);
			end
		endcase
		if (it.eoi)
			cur_col = '0;
		return has;
	endfunction

	function automatic stream_item_t mk(input action_t a, input logic [ROW_W-1:0] top,
			input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color,
			input logic eoi);
		stream_item_t it;
		it.act = a;
		it.top = top;
		it.idx = idx;
		it.color = color;
		it.eoi = eoi;
		return it;
	endfunction

	// Only palette entries already written may be looked up.
	function automatic logic [INDEX_W-1:0] pick_index();
		logic [INDEX_W-1:0] idx;
		do begin
			idx = INDEX_W'($urandom_range(0, PAL_DEPTH - 1));
		end while (!pal_written[idx]);
		return idx;
	endfunction

	task automatic add_row(input stream_item_t it);
		dir_row_t r;
		r.item = it;
		r.typed = 1'b0;
		r.want = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_checked(input stream_item_t it, input fb_write_t want);
		dir_row_t r;
		r.item = it;
		r.typed = 1'b1;
		r.want = want;
		dir_rows.push_back(r);
	endtask

	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		err_count++;
	endtask

	// Leaves valid high after the beat so that back-to-back items need no toggle.
	task automatic send_item(input stream_item_t it, input bit typed, input fb_write_t want);
		int        gap;
		fb_write_t wr;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.action <= it.act;
		stream_if.post_top <= it.top;
		stream_if.palette_index <= it.idx;
		stream_if.color_word <= it.color;
		stream_if.end_of_image <= it.eoi;
		stream_if.valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!stream_if.ready);
		if (decode_item(it, wr))
			pending_writes.push_back(typed ? want : wr);
		items_sent++;
	endtask

	task automatic send_plain(input stream_item_t it);
		send_item(it, 1'b0, '0);
	endtask

	// Writes both size registers once the block has drained.
	task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		stream_if.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_if.index <= REG_WIDTH;
		cfg_if.data <= w;
		cfg_if.valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		cfg_width = w;
		cfg_if.index <= REG_HEIGHT;
		cfg_if.data <= h;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		cfg_height = h;
		cfg_if.valid <= 1'b0;
	endtask

	// One well-formed column: optional palette writes, a few posts, a column end.
	task automatic send_column();
		int               n_pal;
		int               n_posts;
		int               n_pix;
		int               top_hi;
		logic [DIM_W-1:0] w_eff;
		bit               eoi;
		n_pal = $urandom_range(0, 2);
		n_posts = $urandom_range(1, 3);
		repeat (n_pal)
			send_plain(mk(ACT_PALETTE, ROW_W'($urandom_range(0, 254)),
				INDEX_W'($urandom_range(0, 255)), $urandom(), 1'b0));
		repeat (n_posts) begin
			top_hi = int'(eff_dim(cfg_height));
			if (top_hi > 254)
				top_hi = 254;
			send_plain(mk(ACT_POST_START, ROW_W'($urandom_range(0, top_hi)),
				INDEX_W'($urandom_range(0, 255)), $urandom(), 1'b0));
			n_pix = $urandom_range(1, 8);
			repeat (n_pix)
				send_plain(mk(ACT_POST_PIXEL, ROW_W'($urandom_range(0, 254)),
					pick_index(), $urandom(), 1'b0));
		end
		w_eff = eff_dim(cfg_width);
		eoi = (cur_col + DIM_W'(1) >= w_eff) || ($urandom_range(0, 24) == 0);
		send_plain(mk(ACT_COLUMN_END, ROW_W'($urandom_range(0, 254)),
			INDEX_W'($urandom_range(0, 255)), $urandom(), eoi));
	endtask

	task automatic send_noise();
		action_t            a;
		logic [INDEX_W-1:0] idx;
		a = action_t'($urandom_range(0, 3));
		idx = (a == ACT_POST_PIXEL) ? pick_index() : INDEX_W'($urandom_range(0, 255));
		send_plain(mk(a, ROW_W'($urandom_range(0, 254)), idx, $urandom(),
			$urandom_range(0, 7) == 0));
	endtask

	// Result receiver: random stalls, plus one long hold-off on request.
	initial begin
		int        stall;
		fb_write_t want;
		result_if.ready <= 1'b0;
		wait (rx_started);
		forever begin
			if (rx_hold_len != 0) begin
				stall = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				stall = rx_fast ? 0 : $urandom_range(0, 10);
			end
			if (stall != 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!result_if.valid);
			if (pending_writes.size() == 0) begin
				report("write with nothing pending, address", 32'(result_if.pixel_address), '0);
			end else begin
				want = pending_writes.pop_front();
				if (result_if.pixel_address !== want.addr)
					report("pixel_address", 32'(result_if.pixel_address), 32'(want.addr));
				if (result_if.pixel_color !== want.color)
					report("pixel_color", result_if.pixel_color, want.color);
				if (result_if.out_of_range !== want.oor)
					report("out_of_range", 32'(result_if.out_of_range), 32'(want.oor));
			end
		end
	end

	// Ends the run when no channel has moved a beat for too long.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int               p;
		int               start;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;

		arst_n <= 1'b0;
		stream_if.valid <= 1'b0;
		stream_if.action <= ACT_PALETTE;
		stream_if.post_top <= '0;
		stream_if.palette_index <= '0;
		stream_if.color_word <= '0;
		stream_if.end_of_image <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_WIDTH;
		cfg_if.data <= '0;
		foreach (pal_written[i]) begin
			pal_written[i] = 1'b0;
			pal_color[i] = '0;
		end
		cur_col = '0;
		cur_row = '0;
		cfg_width = RESET_WIDTH;
		cfg_height = RESET_HEIGHT;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rx_started = 1'b1;

		// Directed table, run at the reset picture size of 64 by 64.
		add_row(mk(ACT_PALETTE, 8'd0, 8'h00, 32'h0000_0000, 1'b0));
		add_row(mk(ACT_PALETTE, 8'd0, 8'hFF, 32'hFFFF_FFFF, 1'b0));
		add_row(mk(ACT_PALETTE, 8'd0, 8'h5A, 32'hA5A5_5A5A, 1'b0));
		add_checked(mk(ACT_POST_PIXEL, 8'd0, 8'hFF, 32'h0, 1'b0), '{18'd0, 32'hFFFF_FFFF, 1'b0});
		add_checked(mk(ACT_POST_PIXEL, 8'd0, 8'h00, 32'h0, 1'b0), '{18'd64, 32'h0, 1'b0});
		add_row(mk(ACT_POST_START, 8'd254, 8'h00, 32'h0, 1'b0));
		add_checked(mk(ACT_POST_PIXEL, 8'd0, 8'h5A, 32'h0, 1'b0), '{18'd0, 32'hA5A5_5A5A, 1'b1});
		add_row(mk(ACT_POST_START, 8'd63, 8'h00, 32'h0, 1'b0));
		add_row(mk(ACT_COLUMN_END, 8'd0, 8'h00, 32'h0, 1'b0));
		add_checked(mk(ACT_POST_PIXEL, 8'd0, 8'hFF, 32'h0, 1'b0),
			'{18'd4033, 32'hFFFF_FFFF, 1'b0});
		add_checked(mk(ACT_POST_PIXEL, 8'd0, 8'h00, 32'h0, 1'b1), '{18'd0, 32'h0, 1'b1});
		add_row(mk(ACT_POST_START, 8'd0, 8'h00, 32'h0, 1'b1));
		add_row(mk(ACT_COLUMN_END, 8'd0, 8'h00, 32'h0, 1'b1));
		add_checked(mk(ACT_POST_PIXEL, 8'd0, 8'h5A, 32'h0, 1'b0), '{18'd0, 32'hA5A5_5A5A, 1'b0});
		add_row(mk(ACT_PALETTE, 8'd0, 8'h81, 32'h8000_0001, 1'b1));
		add_row(mk(ACT_COLUMN_END, 8'd0, 8'h00, 32'h0, 1'b0));
		add_row(mk(ACT_COLUMN_END, 8'd0, 8'h00, 32'h0, 1'b0));
		add_row(mk(ACT_POST_PIXEL, 8'd0, 8'h81, 32'h0, 1'b0));
		add_row(mk(ACT_POST_START, 8'h55, 8'h00, 32'h0, 1'b0));
		add_row(mk(ACT_POST_PIXEL, 8'd0, 8'h81, 32'h0, 1'b0));
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		// Row saturation: the row counter must stick at its top value.
		write_size(10'h3FF, 10'h3FF);
		send_plain(mk(ACT_POST_PIXEL, 8'd0, pick_index(), 32'h0, 1'b0));
		send_plain(mk(ACT_COLUMN_END, 8'd0, 8'h00, 32'h0, 1'b0));
		send_plain(mk(ACT_COLUMN_END, 8'd0, 8'h00, 32'h0, 1'b1));
		send_plain(mk(ACT_POST_START, 8'd254, 8'h00, 32'h0, 1'b0));
		rx_fast = 1'b1;
		repeat (780)
			send_plain(mk(ACT_POST_PIXEL, 8'd0, pick_index(), $urandom(), 1'b0));
		rx_fast = 1'b0;
		send_plain(mk(ACT_POST_START, 8'd0, 8'h00, 32'h0, 1'b0));

		// Random column-post streams under several picture sizes.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin w = 10'd24;  h = 10'd20;  end
				1: begin w = 10'd0;   h = 10'd64;  end
				2: begin w = 10'd64;  h = 10'd0;   end
				3: begin w = 10'd1;   h = 10'd1;   end
				4: begin w = 10'd512; h = 10'd512; end
				5: begin w = 10'h3FF; h = 10'h3FF; end
				6: begin w = 10'd513; h = 10'd300; end
				default: begin
					w = DIM_W'($urandom_range(1, 48));
					h = DIM_W'($urandom_range(1, 48));
				end
			endcase
			write_size(w, h);
			tx_burst = (p % 3 == 1);
			rx_fast = (p % 3 == 2);
			// First phase: the receiver stalls long enough for the input to back up.
			if (p == 0)
				rx_hold_len = 80;
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 85)
					send_column();
				else
					send_noise();
			end
		end

		stream_if.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/cpid_pkg.sv
hdl/cpid_in_if.sv
hdl/cpid_out_if.sv
hdl/cpid_cfg_if.sv
hdl/cpid_front.sv
hdl/cpid_fifo.sv
hdl/cpid_back.sv
hdl/column_post_image_decoder.sv
tb/testbench.sv
